// ===== hdl/plti_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and sizes for the piecewise-linear table interpolator.
// No dependencies; every other file depends on this package.
package plti_pkg;

  // Table geometry
  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  // Word field widths
  localparam int ActionW = 2;
  localparam int AngleW  = 16;
  localparam int ValueW  = 16;
  localparam int StatusW = 3;

  // Interpolation arithmetic: 17-bit differences, 34-bit product,
  // 32-bit dividend magnitude, 16-bit divisor.
  localparam int DiffW   = AngleW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int DivW    = 32;
  localparam int DenW    = 16;
  localparam int DivCntW = $clog2(DivW);

  typedef enum logic [ActionW-1:0] {
    ACT_QUERY  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_EXACT    = 3'd0,
    ST_INTERP   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_STORED   = 3'd3,
    ST_FULL_CLR = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EVAL,
    FSM_MUL,
    FSM_DSTART,
    FSM_DWAIT,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic signed [ValueW-1:0] value;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;     // latch query angle, restart scan
    logic    append_wr;  // store the incoming entry
    logic    clear;      // empty the table
    logic    scan_en;    // step the table scan
    logic    mul_load;   // register product and divisor
    logic    div_start;  // launch the divider
    logic    res_load;   // load the output word
    status_e res_sel;    // status of the output word
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_done;
    logic exact_found;
    logic br_found;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== hdl/plti_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and output words.
// Depends on plti_pkg for field widths.
interface plti_in_if;
  logic                               valid;
  logic                               ready;
  logic [plti_pkg::ActionW-1:0]       action;
  logic signed [plti_pkg::AngleW-1:0] angle;
  logic signed [plti_pkg::ValueW-1:0] entry_position;

  modport source (output valid, action, angle, entry_position, input ready);
  modport sink   (input valid, action, angle, entry_position, output ready);
endinterface

interface plti_out_if;
  logic                               valid;
  logic                               ready;
  logic [plti_pkg::StatusW-1:0]       status;
  logic signed [plti_pkg::ValueW-1:0] position;

  modport source (output valid, status, position, input ready);
  modport sink   (input valid, status, position, output ready);
endinterface

// ===== hdl/plti_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on plti_pkg for operand widths.
module plti_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [plti_pkg::DivW-1:0]     dividend_i,
  input  logic [plti_pkg::DenW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [plti_pkg::DivW-1:0]     quotient_o
);
  import plti_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DenW-1:0]    rem_q, rem_d;
  logic [DenW-1:0]    den_q, den_d;
  logic [DenW:0]      trial;
  logic               ge;

  // Operand load on start, else one shift-and-subtract step
  always_comb begin
    trial  = {rem_q, quo_q[DivW-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Done only closes a running division
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

// ===== hdl/plti_dp.sv =====
`timescale 1ns / 1ps
// Datapath: breakpoint memory, scan registers, multiplier, divider, output word.
// Depends on plti_pkg and plti_div.
module plti_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [plti_pkg::AngleW-1:0] in_angle_i,
  input  logic signed [plti_pkg::ValueW-1:0] in_position_i,
  input  plti_pkg::ctrl_cmd_t                cmd_i,
  output plti_pkg::dp_sts_t                  sts_o,
  output logic [plti_pkg::StatusW-1:0]       out_status_o,
  output logic signed [plti_pkg::ValueW-1:0] out_position_o
);
  import plti_pkg::*;

  entry_t mem_q [TableDepth];
  entry_t rdata_q;
  entry_t prev_q;

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic                     rd_en;
  logic                     rd_vld_q;
  logic                     have_prev_q, have_prev_d;
  logic                     exact_q, exact_d;
  logic                     br_q, br_d;
  logic                     hit_exact, hit_br;

  logic signed [AngleW-1:0] q_q;
  logic signed [ValueW-1:0] ex_val_q;
  logic signed [AngleW-1:0] la_q, ua_q;
  logic signed [ValueW-1:0] lv_q, uv_q;

  logic signed [DiffW-1:0]  dq, dv, den;
  logic signed [ProdW-1:0]  prod_q;
  logic [DenW-1:0]          den_q;
  logic [ProdW-1:0]         prod_mag;
  logic                     div_done;
  logic [DivW-1:0]          quo;
  logic signed [ValueW+1:0] step, interp;

  logic [StatusW-1:0]       status_q;
  logic signed [ValueW-1:0] pos_q, pos_d;

  // Entry count and scan pointer
  assign rd_en = cmd_i.scan_en && (idx_q < cnt_q);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.append_wr) begin
      cnt_d = cnt_q + 1'b1;
    end
    idx_d = idx_q;
    if (cmd_i.accept) begin
      idx_d = '0;
    end else if (rd_en) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // Match tests on the word read last cycle
  assign hit_exact = rd_vld_q && !exact_q && (rdata_q.angle == q_q);
  assign hit_br    = rd_vld_q && have_prev_q && !br_q &&
                     (prev_q.angle < q_q) && (rdata_q.angle > q_q);

  always_comb begin
    have_prev_d = have_prev_q;
    exact_d     = exact_q;
    br_d        = br_q;
    if (cmd_i.accept) begin
      have_prev_d = 1'b0;
      exact_d     = 1'b0;
      br_d        = 1'b0;
    end else begin
      if (rd_vld_q) have_prev_d = 1'b1;
      if (hit_exact) exact_d = 1'b1;
      if (hit_br) br_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      have_prev_q <= 1'b0;
      exact_q     <= 1'b0;
      br_q        <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_en;
      have_prev_q <= have_prev_d;
      exact_q     <= exact_d;
      br_q        <= br_d;
    end
  end

  // Breakpoint memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append_wr) begin
      mem_q[cnt_q[IdxW-1:0]] <= '{angle: in_angle_i, value: in_position_i};
    end
    if (rd_en) begin
      rdata_q <= mem_q[idx_q[IdxW-1:0]];
    end
  end

  // Scan payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) q_q <= in_angle_i;
    if (rd_vld_q) prev_q <= rdata_q;
    if (hit_exact) ex_val_q <= rdata_q.value;
    if (hit_br) begin
      la_q <= prev_q.angle;
      lv_q <= prev_q.value;
      ua_q <= rdata_q.angle;
      uv_q <= rdata_q.value;
    end
  end

  // Product (q - la) * (uv - lv) and divisor ua - la
  assign dq  = DiffW'(q_q) - DiffW'(la_q);
  assign dv  = DiffW'(uv_q) - DiffW'(lv_q);
  assign den = DiffW'(ua_q) - DiffW'(la_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= dq * dv;
      den_q  <= den[DenW-1:0];
    end
  end

  // Divide magnitudes; the sign is reapplied afterwards
  assign prod_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);

  plti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_mag[DivW-1:0]),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Quotient magnitude is below |uv - lv|, so 16 bits hold it
  assign step   = {2'b00, quo[ValueW-1:0]};
  assign interp = (ValueW+2)'(lv_q) + (prod_q[ProdW-1] ? -step : step);

  // Output word
  always_comb begin
    case (cmd_i.res_sel)
      ST_EXACT:  pos_d = ex_val_q;
      ST_INTERP: pos_d = interp[ValueW-1:0];
      default:   pos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_sel;
      pos_q    <= pos_d;
    end
  end

  assign sts_o.empty       = (cnt_q == '0);
  assign sts_o.full        = (cnt_q == CntW'(TableDepth));
  assign sts_o.scan_done   = (idx_q == cnt_q) && !rd_vld_q;
  assign sts_o.exact_found = exact_q;
  assign sts_o.br_found    = br_q;
  assign sts_o.div_done    = div_done;
  assign out_status_o      = status_q;
  assign out_position_o    = pos_q;

  // Scan pointer never passes the fill level
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_en |-> idx_q <= cnt_q)
    else $error("scan pointer beyond entry count");

  // Appends never push the count past the table
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append_wr |-> cnt_q < CntW'(TableDepth))
    else $error("append into a full table");

endmodule

// ===== hdl/plti_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences accept, table scan, multiply, divide and output.
// Depends on plti_pkg.
module plti_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [plti_pkg::ActionW-1:0] in_action_i,
  output logic                         in_ready_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  input  plti_pkg::dp_sts_t            sts_i,
  output plti_pkg::ctrl_cmd_t          cmd_o
);
  import plti_pkg::*;

  fsm_e    state_q, state_d;
  status_e pend_q, pend_d;
  logic    out_valid_q, out_valid_d;
  logic    accept;
  logic    slot_free;

  assign accept    = in_valid_i && (state_q == FSM_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and pending status
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_RESP;
          case (in_action_i)
            ACT_QUERY: begin
              if (sts_i.empty) begin
                pend_d = ST_NOTFOUND;
              end else begin
                state_d = FSM_SCAN;
              end
            end
            ACT_APPEND: pend_d = sts_i.full ? ST_FULL_CLR : ST_STORED;
            ACT_CLEAR:  pend_d = ST_FULL_CLR;
            default:    pend_d = ST_NOTFOUND;
          endcase
        end
      end
      FSM_SCAN: begin
        if (sts_i.scan_done) state_d = FSM_EVAL;
      end
      FSM_EVAL: begin
        if (sts_i.exact_found) begin
          pend_d  = ST_EXACT;
          state_d = FSM_RESP;
        end else if (sts_i.br_found) begin
          state_d = FSM_MUL;
        end else begin
          pend_d  = ST_NOTFOUND;
          state_d = FSM_RESP;
        end
      end
      FSM_MUL:    state_d = FSM_DSTART;
      FSM_DSTART: state_d = FSM_DWAIT;
      FSM_DWAIT: begin
        if (sts_i.div_done) begin
          pend_d  = ST_INTERP;
          state_d = FSM_RESP;
        end
      end
      FSM_RESP: begin
        if (slot_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.res_sel   = pend_q;
    cmd_o.accept    = accept;
    cmd_o.append_wr = accept && (in_action_i == ACT_APPEND) && !sts_i.full;
    cmd_o.clear     = accept && (in_action_i == ACT_CLEAR);
    cmd_o.scan_en   = (state_q == FSM_SCAN);
    cmd_o.mul_load  = (state_q == FSM_MUL);
    cmd_o.div_start = (state_q == FSM_DSTART);
    cmd_o.res_load  = (state_q == FSM_RESP) && slot_free;
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      pend_q      <= ST_NOTFOUND;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == FSM_IDLE);
  assign out_valid_o = out_valid_q;

  // A new word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");

  // A loaded word is offered next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> out_valid_q)
    else $error("loaded word not offered");

  // Query on an empty table skips the scan
  a_empty_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_action_i == ACT_QUERY) && sts_i.empty) |=>
      (state_q == FSM_RESP) && (pend_q == ST_NOTFOUND))
    else $error("empty-table query entered the scan");

endmodule

// ===== hdl/piecewise_linear_table_interpolator.sv =====
`timescale 1ns / 1ps
// Piecewise-linear table interpolator, top level.
// Append, clear and unused actions go from accept straight to the result load,
// which waits for a free output slot. Query: one memory read per stored entry,
// then a 32-step serial divider when interpolating.
// One word in flight; a new word is taken while the last result waits.
// Reset clears the entry count and control; table contents are undefined.
module piecewise_linear_table_interpolator (
  input  logic       clk_i,
  input  logic       rst_ni,
  plti_in_if.sink    in_i,
  plti_out_if.source out_o
);
  import plti_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  plti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  plti_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_angle_i     (in_i.angle),
    .in_position_i  (in_i.entry_position),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_status_o   (out_o.status),
    .out_position_o (out_o.position)
  );

endmodule
